// File: sv/srfbs_pkg.sv
// ----------------------------------------------------------------------------
// srfbs_pkg
// Shared types, character codes and address window constants for the
// S-record parser and flash block splitter.
// ----------------------------------------------------------------------------
package srfbs_pkg;

  localparam logic [7:0]  CH_CR       = 8'h0D;
  localparam logic [7:0]  CH_LF       = 8'h0A;

  localparam logic [31:0] WIN_LO      = 32'h0000_8000;
  localparam logic [31:0] WIN_HI      = 32'h0000_BFFF;
  localparam logic [31:0] WIN_SHIFT   = 32'h0000_4000;
  localparam logic [15:0] SKIP_RESET  = 16'h0400;

  localparam logic [3:0]  AD_DIGITS16 = 4'd4;
  localparam logic [3:0]  AD_DIGITS24 = 4'd6;
  localparam logic [3:0]  AD_DIGITS32 = 4'd8;

  localparam logic [9:0]  POS_MAX     = 10'd1023;

  localparam logic        KIND_DATA   = 1'b0;
  localparam logic        KIND_END    = 1'b1;

  // Record type digits.
  typedef enum logic [3:0] {
    REC_HEADER   = 4'd0,
    REC_DATA16   = 4'd1,
    REC_DATA24   = 4'd2,
    REC_DATA32   = 4'd3,
    REC_RESERVED = 4'd4,
    REC_COUNT16  = 4'd5,
    REC_COUNT24  = 4'd6,
    REC_START32  = 4'd7,
    REC_START24  = 4'd8,
    REC_START16  = 4'd9
  } rec_type_t;

  // Events from the record parser to the block splitter for one character.
  typedef struct packed {
    logic        rec_start;
    logic        load;
    logic [31:0] load_addr;
    logic        emit;
    logic [7:0]  data;
    logic        rec_end;
    logic [3:0]  record_type;
    logic        checksum_ok;
    logic        count_short;
  } parse_evt_t;

  // One result transaction.
  typedef struct packed {
    logic        kind;
    logic [31:0] address;
    logic [7:0]  data;
    logic        first_of_block;
    logic        skipped;
    logic        page_change;
    logic [7:0]  page;
    logic [3:0]  record_type;
    logic        checksum_ok;
    logic        count_short;
  } result_t;

  // Hex digit decode; anything that is not a hex digit reads as zero.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c inside {[8'h30:8'h39]}) begin
      v = c - 8'h30;
    end else if (c inside {[8'h41:8'h46]}) begin
      v = c - 8'h37;
    end else if (c inside {[8'h61:8'h66]}) begin
      v = c - 8'h57;
    end
    return v[3:0];
  endfunction

  function automatic logic in_window(input logic [31:0] a);
    return (a >= WIN_LO) && (a <= WIN_HI);
  endfunction

endpackage

// File: sv/srecord_flash_block_splitter.sv
// ----------------------------------------------------------------------------
// srecord_flash_block_splitter
// S-record text parser that emits data bytes with their flash addresses,
// split into write blocks, plus one status transaction per record.
// ----------------------------------------------------------------------------
// The block takes one character per clock cycle while in_ready is high and
// produces at most one result per character. A character is captured in an
// input register; when it advances, the parser and block splitter update
// their state in a single pass and load the result register. While a result
// waits for out_ready the input register can still take one more character;
// after that in_ready stays low until the result is taken. The sustained
// rate is one character per cycle when the sink keeps up.
// skip_below may only be written while no characters are in flight.
module srecord_flash_block_splitter import srfbs_pkg::*; #(
  parameter int BLOCK_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_skip_below,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_ch,

  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [31:0] out_address,
  output logic [7:0]  out_data,
  output logic        out_first_of_block,
  output logic        out_skipped,
  output logic        out_page_change,
  output logic [7:0]  out_page,
  output logic [3:0]  out_record_type,
  output logic        out_checksum_ok,
  output logic        out_count_short
);

  logic [15:0] skip_below_r;
  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_ch_r;
  logic        out_valid_r, out_valid_nxt;
  result_t     out_res_r;

  parse_evt_t  evt;
  result_t     res;
  logic        adv;
  logic        has_result;

  assign cfg_ready  = 1'b1;
  assign adv        = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready   = !s1_valid_r || adv;
  assign has_result = evt.emit || evt.rec_end;

  srfbs_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .ch    (s1_ch_r),
    .evt   (evt)
  );

  srfbs_blocker #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_blocker (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (adv),
    .skip_below (skip_below_r),
    .evt        (evt),
    .res        (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = has_result;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_below_r <= SKIP_RESET;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        skip_below_r <= cfg_skip_below;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_ch_r <= in_ch;
    end
    if (adv && has_result) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_res_r.kind;
  assign out_address        = out_res_r.address;
  assign out_data           = out_res_r.data;
  assign out_first_of_block = out_res_r.first_of_block;
  assign out_skipped        = out_res_r.skipped;
  assign out_page_change    = out_res_r.page_change;
  assign out_page           = out_res_r.page;
  assign out_record_type    = out_res_r.record_type;
  assign out_checksum_ok    = out_res_r.checksum_ok;
  assign out_count_short    = out_res_r.count_short;

  // With the result register empty, the input side must never stall.
  a_ready_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled while result register empty");

  // A transaction that produces a result must show up at the output.
  a_result_loaded : assert property (@(posedge clk) disable iff (!rst_n)
    adv && has_result |=> out_valid)
    else $error("result lost after state update");

  // A skipped block never triggers a page erase.
  a_skip_no_erase : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_DATA) && out_skipped |-> !out_page_change)
    else $error("page change raised for a skipped block");

endmodule

// File: sv/srfbs_parser.sv
// ----------------------------------------------------------------------------
// srfbs_parser
// Record field parser: tracks the character position within a line and
// decodes type, count, address, data and checksum fields.
// ----------------------------------------------------------------------------
module srfbs_parser import srfbs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] ch,
  output parse_evt_t evt
);

  logic [9:0]  pos_r, pos_nxt;
  logic        open_r, open_nxt;
  logic [3:0]  type_r, type_nxt;
  logic [3:0]  hn_r, hn_nxt;
  logic [7:0]  bc_r, bc_nxt;
  logic [3:0]  ad_r, ad_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  dl_r, dl_nxt;

  // Record fields as seen by this character (cleared when a line opens).
  logic [3:0]  hn_e;
  logic [7:0]  bc_e;
  logic [31:0] acc_e;
  logic [7:0]  sum_e;
  logic [7:0]  dl_e;

  logic        eol;
  logic [3:0]  nib;
  logic [7:0]  byte_val;
  logic [7:0]  need;
  logic [7:0]  dlen;
  logic [9:0]  addr_end;
  logic [9:0]  data_off;
  logic [8:0]  idx;

  assign hn_e  = open_r ? hn_r  : 4'd0;
  assign bc_e  = open_r ? bc_r  : 8'd0;
  assign acc_e = open_r ? acc_r : 32'd0;
  assign sum_e = open_r ? sum_r : 8'd0;
  assign dl_e  = open_r ? dl_r  : 8'd0;

  assign eol      = (ch == CH_CR) || (ch == CH_LF);
  assign nib      = hex_value(ch);
  assign byte_val = {hn_e, nib};
  assign need     = 8'(ad_r[3:1]) + 8'd1;
  assign dlen     = (bc_e > need) ? (bc_e - need) : 8'd0;
  assign addr_end = 10'(ad_r) + 10'd4;
  assign data_off = pos_r - addr_end;
  assign idx      = data_off[9:1];

  always_comb begin
    pos_nxt  = pos_r;
    open_nxt = open_r;
    type_nxt = type_r;
    hn_nxt   = hn_r;
    bc_nxt   = bc_r;
    ad_nxt   = ad_r;
    acc_nxt  = acc_r;
    sum_nxt  = sum_r;
    dl_nxt   = dl_r;
    evt             = '0;
    evt.record_type = type_r;

    if (eol) begin
      evt.rec_end     = open_r;
      evt.checksum_ok = (sum_r == 8'hFF);
      evt.count_short = (bc_r < need);
      open_nxt        = 1'b0;
      pos_nxt         = 10'd0;
    end else begin
      evt.rec_start = !open_r;
      open_nxt      = 1'b1;
      hn_nxt        = hn_e;
      bc_nxt        = bc_e;
      acc_nxt       = acc_e;
      sum_nxt       = sum_e;
      dl_nxt        = dl_e;

      if (pos_r == 10'd1) begin
        if (ch inside {[8'h30:8'h39]}) begin
          type_nxt = ch[3:0];
          case (ch[3:0])
            REC_HEADER, REC_DATA16, REC_START16: ad_nxt = AD_DIGITS16;
            REC_DATA24, REC_START24:             ad_nxt = AD_DIGITS24;
            REC_DATA32, REC_START32:             ad_nxt = AD_DIGITS32;
            default:                             ad_nxt = ad_r;
          endcase
        end
      end else if (pos_r >= 10'd2) begin
        if ((pos_r >= 10'd4) && (pos_r < addr_end)) begin
          acc_nxt = {acc_e[27:0], nib};
        end
        if (!pos_r[0]) begin
          hn_nxt = nib;
        end else if (pos_r == 10'd3) begin
          bc_nxt  = byte_val;
          sum_nxt = sum_e + byte_val;
        end else if (pos_r < addr_end) begin
          sum_nxt = sum_e + byte_val;
          if (pos_r == addr_end - 10'd1) begin
            // Last address digit: hand the remapped start address over.
            evt.load      = 1'b1;
            evt.load_addr = in_window(acc_nxt) ? (acc_nxt - WIN_SHIFT) : acc_nxt;
            dl_nxt        = dlen;
          end
        end else begin
          if (dl_e != 8'd0) begin
            evt.emit = 1'b1;
            evt.data = byte_val;
            sum_nxt  = sum_e + byte_val;
            dl_nxt   = dl_e - 8'd1;
          end else if (idx == 9'(dlen)) begin
            // The checksum byte itself.
            sum_nxt = sum_e + byte_val;
          end
        end
      end

      if (pos_r < POS_MAX) begin
        pos_nxt = pos_r + 10'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 10'd0;
      open_r <= 1'b0;
      type_r <= 4'd0;
      hn_r   <= 4'd0;
      bc_r   <= 8'd0;
      ad_r   <= AD_DIGITS16;
      acc_r  <= 32'd0;
      sum_r  <= 8'd0;
      dl_r   <= 8'd0;
    end else if (step) begin
      pos_r  <= pos_nxt;
      open_r <= open_nxt;
      type_r <= type_nxt;
      hn_r   <= hn_nxt;
      bc_r   <= bc_nxt;
      ad_r   <= ad_nxt;
      acc_r  <= acc_nxt;
      sum_r  <= sum_nxt;
      dl_r   <= dl_nxt;
    end
  end

endmodule

// File: sv/srfbs_blocker.sv
// ----------------------------------------------------------------------------
// srfbs_blocker
// Flash block splitter: assigns target addresses to data bytes, cuts write
// blocks and tracks the skip flag and the current flash page.
// ----------------------------------------------------------------------------
module srfbs_blocker import srfbs_pkg::*; #(
  parameter int BLOCK_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [15:0] skip_below,
  input  parse_evt_t  evt,
  output result_t     res
);

  localparam int BIB_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;

  logic [31:0]      target_r, target_nxt;
  logic [BIB_W-1:0] bib_r, bib_nxt;
  logic             skip_r, skip_nxt;
  logic [7:0]       last_page_r, last_page_nxt;

  logic             first;
  logic             change;
  logic             ends;
  logic [31:0]      target_inc;

  assign first      = (bib_r == '0);
  assign ends       = (bib_r == BIB_W'(BLOCK_BYTES - 1)) || (target_r == WIN_LO - 32'd1);
  assign target_inc = target_r + 32'd1;

  always_comb begin
    target_nxt    = target_r;
    bib_nxt       = bib_r;
    skip_nxt      = skip_r;
    last_page_nxt = last_page_r;
    change        = 1'b0;
    res           = '0;
    res.record_type = evt.record_type;

    if (evt.rec_start) begin
      bib_nxt = '0;
    end
    if (evt.load) begin
      target_nxt = evt.load_addr;
      bib_nxt    = '0;
    end

    if (evt.emit) begin
      if (first) begin
        skip_nxt = (target_r < {16'd0, skip_below});
        if (!skip_nxt && (target_r[31:16] != {8'd0, last_page_r})) begin
          change        = 1'b1;
          last_page_nxt = target_r[23:16];
        end
      end
      res.kind           = KIND_DATA;
      res.address        = target_r;
      res.data           = evt.data;
      res.first_of_block = first;
      res.skipped        = skip_nxt;
      res.page_change    = change;
      res.page           = target_r[23:16];

      // A finished block moves an address that lands in the window back up.
      if (ends) begin
        bib_nxt    = '0;
        target_nxt = in_window(target_inc) ? (target_inc + WIN_SHIFT) : target_inc;
      end else begin
        bib_nxt    = bib_r + BIB_W'(1);
        target_nxt = target_inc;
      end
    end else if (evt.rec_end) begin
      res.kind        = KIND_END;
      res.checksum_ok = evt.checksum_ok;
      res.count_short = evt.count_short;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= 32'd0;
      bib_r       <= '0;
      skip_r      <= 1'b0;
      last_page_r <= 8'd0;
    end else if (step) begin
      target_r    <= target_nxt;
      bib_r       <= bib_nxt;
      skip_r      <= skip_nxt;
      last_page_r <= last_page_nxt;
    end
  end

endmodule
